[rtl/core/mvfam_pkg.sv]
// Package: shared constants, op codes and controller-datapath command types.
package mvfam_pkg;
	localparam int VOICE_COUNT = 16;
	localparam int VOICE_W = $clog2(VOICE_COUNT);
	localparam int FIFO_DEPTH = 4096;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int MEM_AW = VOICE_W + PTR_W;

	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_PLAY  = 3'd2;
	localparam logic [2:0] OP_GAIN  = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;

	localparam logic [PTR_W-1:0] FILL_MAX = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [15:0] UNITY_GAIN = 16'd32768;
	localparam logic [11:0] THRESH_RESET = 12'd2048;

	typedef struct packed {
		logic             latch;   // capture request fields
		logic             simple;  // execute a non-tick op
		logic             rd_fetch; // read pointer/gain/playing of tick voice, issue mem read
		logic             mac;     // multiply-accumulate fetched sample
		logic             done;    // present result
		logic [VOICE_W-1:0] tv;    // tick voice
	} mvfam_cmd_t;

	typedef struct packed {
		logic fetch_ok; // tick voice playing and non-empty
	} mvfam_sts_t;
endpackage

[rtl/core/mvfam_ctrl.sv]
// Controller: sequences one request, walking the voices for a mix tick.
module mvfam_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            op,
	input  mvfam_pkg::mvfam_sts_t sts,
	output logic                  busy,
	output mvfam_pkg::mvfam_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_FETCH = 3'd2,
		S_WAIT = 3'd3, S_MAC = 3'd4, S_DONE = 3'd5;
	logic [2:0] state_q;
	logic [mvfam_pkg::VOICE_W-1:0] tv_q;
	logic is_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tv_q <= '0;
			is_tick_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					is_tick_q <= (op == mvfam_pkg::OP_TICK);
					tv_q <= '0;
					state_q <= S_EXEC;
				end
				S_EXEC: state_q <= is_tick_q ? S_FETCH : S_DONE;
				S_FETCH: state_q <= sts.fetch_ok ? S_WAIT : S_MAC;
				S_WAIT: state_q <= S_MAC;
				S_MAC: begin
					tv_q <= tv_q + 1'b1;
					state_q <= (tv_q == mvfam_pkg::VOICE_W'(mvfam_pkg::VOICE_COUNT - 1))
						? S_DONE : S_FETCH;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	always_comb begin
		cmd.latch = (state_q == S_IDLE) && start;
		cmd.simple = (state_q == S_EXEC) && !is_tick_q;
		cmd.rd_fetch = (state_q == S_FETCH);
		cmd.mac = (state_q == S_MAC);
		cmd.done = (state_q == S_DONE);
		cmd.tv = tv_q;
	end
endmodule

[rtl/core/mvfam_dp.sv]
// Datapath: voice state, sample memory, multiplier and saturating accumulator.
module mvfam_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mvfam_pkg::mvfam_cmd_t cmd,
	output mvfam_pkg::mvfam_sts_t sts,
	input  logic [2:0]            op,
	input  logic [3:0]            voice,
	input  logic signed [15:0]    sample_in,
	input  logic [15:0]           gain_value,
	input  logic                  play_on,
	input  logic                  cfg_we,
	input  logic [11:0]           cfg_wdata,
	output logic                  strobe,
	output logic signed [15:0]    mixed_sample,
	output logic                  accepted,
	output logic [15:0]           refill_mask,
	output logic [11:0]           voice_fill
);
	localparam int VC = mvfam_pkg::VOICE_COUNT;
	localparam int PW = mvfam_pkg::PTR_W;
	logic [PW-1:0] wp_q [VC];
	logic [PW-1:0] rp_q [VC];
	logic [15:0] gain_q [VC];
	logic [VC-1:0] play_q;
	logic [VC-1:0] flags_q;
	logic [11:0] thr_q;
	logic [15:0] mem [2**mvfam_pkg::MEM_AW];
	logic [15:0] rdata_q;

	logic [2:0] op_q;
	logic [3:0] v_q;
	logic [15:0] smp_q, gv_q;
	logic pl_q;
	logic signed [16:0] acc_q;
	logic [15:0] g_s1;
	logic [PW-1:0] fill_s1;
	logic fetched_q;

	logic [PW-1:0] fill_v, fill_t;
	assign fill_v = wp_q[v_q] - rp_q[v_q];
	assign fill_t = wp_q[cmd.tv] - rp_q[cmd.tv];
	assign sts.fetch_ok = play_q[cmd.tv] && (fill_t != '0);

	logic signed [32:0] prod;
	logic signed [32:0] mag;
	logic signed [17:0] scaled;
	logic signed [18:0] sum;
	always_comb begin
		prod = $signed(rdata_q) * $signed({1'b0, g_s1});
		mag = prod[32] ? -prod : prod;
		scaled = prod[32] ? -$signed({1'b0, mag[31:15]}) : $signed({1'b0, mag[31:15]});
		sum = 19'(acc_q) + 19'(scaled);
	end

	always_ff @(posedge clk) begin
		if (cmd.simple && op_q == mvfam_pkg::OP_PUSH && fill_v != mvfam_pkg::FILL_MAX)
			mem[{v_q, wp_q[v_q]}] <= smp_q;
		if (cmd.rd_fetch) rdata_q <= mem[{cmd.tv, rp_q[cmd.tv]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VC; i++) begin
				wp_q[i] <= '0; rp_q[i] <= '0; gain_q[i] <= mvfam_pkg::UNITY_GAIN;
			end
			play_q <= '0; flags_q <= '0; thr_q <= mvfam_pkg::THRESH_RESET;
			strobe <= 1'b0; op_q <= '0; v_q <= '0; smp_q <= '0; gv_q <= '0; pl_q <= 1'b0;
			acc_q <= '0; g_s1 <= '0; fill_s1 <= '0; fetched_q <= 1'b0;
			mixed_sample <= '0; accepted <= 1'b0; refill_mask <= '0; voice_fill <= '0;
		end else begin
			strobe <= cmd.done;
			if (cfg_we) thr_q <= cfg_wdata;
			if (cmd.latch) begin
				op_q <= op; v_q <= voice; smp_q <= sample_in; gv_q <= gain_value;
				pl_q <= play_on; acc_q <= '0; accepted <= 1'b0; refill_mask <= '0;
			end
			if (cmd.simple) begin
				case (op_q)
					mvfam_pkg::OP_PUSH: if (fill_v != mvfam_pkg::FILL_MAX) begin
						wp_q[v_q] <= wp_q[v_q] + 1'b1; accepted <= 1'b1;
					end
					mvfam_pkg::OP_PLAY: begin
						play_q[v_q] <= pl_q;
						if (pl_q && fill_v == '0) flags_q[v_q] <= 1'b1;
					end
					mvfam_pkg::OP_GAIN: gain_q[v_q] <= gv_q;
					mvfam_pkg::OP_CLEAR: rp_q[v_q] <= wp_q[v_q];
					mvfam_pkg::OP_READ: begin
						refill_mask <= flags_q; flags_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.rd_fetch) begin
				fetched_q <= sts.fetch_ok;
				g_s1 <= gain_q[cmd.tv];
				fill_s1 <= fill_t - 1'b1;
				if (play_q[cmd.tv] && fill_t == '0) flags_q[cmd.tv] <= 1'b1;
				if (sts.fetch_ok) rp_q[cmd.tv] <= rp_q[cmd.tv] + 1'b1;
			end
			if (cmd.mac && fetched_q) begin
				if (sum > 19'sd32767) acc_q <= 17'sd32767;
				else if (sum < -19'sd32768) acc_q <= -17'sd32768;
				else acc_q <= sum[16:0];
				if (fill_s1 < thr_q) flags_q[cmd.tv] <= 1'b1;
			end
			if (cmd.done) begin
				mixed_sample <= (op_q == mvfam_pkg::OP_TICK) ? acc_q[15:0] : 16'sd0;
				voice_fill <= fill_v;
			end
		end
	end
endmodule

[rtl/core/multi_voice_fifo_audio_mixer.sv]
// Top level: sixteen-voice FIFO audio mixer, controller plus datapath.
//
//  channel   signals                                    direction
//  request   start, busy, op, voice, sample_in,         in (busy out)
//            gain_value, play_on
//  result    strobe, mixed_sample, accepted,            out
//            refill_mask, voice_fill
//  config    cfg_we, cfg_wdata (refill threshold)       in
//
// A mix tick walks the voices in turn through fetch, memory read wait (skipped
// for an idle or empty voice) and accumulate; it is bounded by the single sample-memory
// read port and the one shared multiplier. Other requests need only the execute step.
// The result strobe follows the last step; the receiver cannot stall it.
// Reset clears pointers and flags and sets gains to unity at once; memory content is not cleared.
module multi_voice_fifo_audio_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic [3:0]         voice,
	input  logic signed [15:0] sample_in,
	input  logic [15:0]        gain_value,
	input  logic               play_on,
	input  logic               cfg_we,
	input  logic [11:0]        cfg_wdata,
	output logic               strobe,
	output logic signed [15:0] mixed_sample,
	output logic               accepted,
	output logic [15:0]        refill_mask,
	output logic [11:0]        voice_fill
);
	mvfam_pkg::mvfam_cmd_t cmd;
	mvfam_pkg::mvfam_sts_t sts;

	// Sequence the request.
	mvfam_ctrl u_ctrl (.clk, .arst_n, .start, .op, .sts, .busy, .cmd);

	// Hold voice state and do the arithmetic.
	mvfam_dp u_dp (.clk, .arst_n, .cmd, .sts, .op, .voice, .sample_in, .gain_value,
		.play_on, .cfg_we, .cfg_wdata, .strobe, .mixed_sample, .accepted,
		.refill_mask, .voice_fill);
endmodule

[dv/mvfam_checker.sv]
// Checker for the voice mixer: predicts each result from the request stream and compares.
module mvfam_checker
	import mvfam_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         op,
	input  logic [3:0]         voice,
	input  logic signed [15:0] sample_in,
	input  logic [15:0]        gain_value,
	input  logic               play_on,
	input  logic               cfg_we,
	input  logic [11:0]        cfg_wdata,
	input  logic               strobe,
	input  logic signed [15:0] mixed_sample,
	input  logic               accepted,
	input  logic [15:0]        refill_mask,
	input  logic [11:0]        voice_fill,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] mixed;
		logic        acc;
		logic [15:0] mask;
		logic [11:0] fill;
	} mix_result_t;

	logic [15:0] sample_mem [0:VOICE_COUNT*FIFO_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr [VOICE_COUNT];
	logic [PTR_W-1:0] rd_ptr [VOICE_COUNT];
	logic [15:0] gain_q [VOICE_COUNT];
	logic playing [VOICE_COUNT];
	logic [15:0] flags_q;
	logic [11:0] thresh_q;
	mix_result_t result_q [$];

	function automatic logic [PTR_W-1:0] fill_of(int v);
		return wr_ptr[v] - rd_ptr[v];
	endfunction

	task automatic predict_mix(output logic [15:0] mix);
		longint acc_sum, smp, prod, scaled;
		acc_sum = 0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (!playing[v]) continue;
			if (fill_of(v) == 0) begin
				flags_q[v] = 1'b1;
				continue;
			end
			smp = longint'($signed(sample_mem[v*FIFO_DEPTH + rd_ptr[v]]));
			rd_ptr[v] = rd_ptr[v] + 1'b1;
			prod = smp * longint'(gain_q[v]);
			scaled = (prod < 0) ? -((-prod) >>> 15) : (prod >>> 15);
			acc_sum += scaled;
			if (acc_sum > 32767) acc_sum = 32767;
			else if (acc_sum < -32768) acc_sum = -32768;
			if (fill_of(v) < thresh_q) flags_q[v] = 1'b1;
		end
		mix = acc_sum[15:0];
	endtask

	task automatic predict_request();
		mix_result_t r;
		int v;
		v = voice;
		r = '0;
		case (op)
			OP_PUSH: begin
				if (fill_of(v) < FILL_MAX) begin
					sample_mem[v*FIFO_DEPTH + wr_ptr[v]] = sample_in;
					wr_ptr[v] = wr_ptr[v] + 1'b1;
					r.acc = 1'b1;
				end
			end
			OP_TICK: predict_mix(r.mixed);
			OP_PLAY: begin
				playing[v] = play_on;
				if (play_on && fill_of(v) == 0) flags_q[v] = 1'b1;
			end
			OP_GAIN: gain_q[v] = gain_value;
			OP_CLEAR: rd_ptr[v] = wr_ptr[v];
			OP_READ: begin
				r.mask = flags_q;
				flags_q = '0;
			end
			default: ;
		endcase
		r.fill = fill_of(v);
		result_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		mix_result_t got, want;
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				wr_ptr[v] = '0;
				rd_ptr[v] = '0;
				gain_q[v] = UNITY_GAIN;
				playing[v] = 1'b0;
			end
			flags_q = '0;
			thresh_q = THRESH_RESET;
			result_q.delete();
		end else begin
			// compare first: a result never belongs to the request taken at the same edge
			if (strobe) begin
				got = '{mixed_sample, accepted, refill_mask, voice_fill};
				if (result_q.size() == 0) begin
					$display("%0t: result with no request pending: %p", $time, got);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors++;
					end
				end
			end
			if (cfg_we) thresh_q = cfg_wdata;
			if (start && !busy) predict_request();
		end
		pending = result_q.size();
	end

	initial begin
		errors = 0;
		pending = 0;
	end
endmodule

[dv/tb.sv]
// Testbench top: clock, reset, request stimulus and the final verdict for the voice mixer.
module tb;
	import mvfam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk, arst_n;
	logic start, busy;
	logic [2:0] op;
	logic [3:0] voice;
	logic signed [15:0] sample_in;
	logic [15:0] gain_value;
	logic play_on;
	logic cfg_we;
	logic [11:0] cfg_wdata;
	logic strobe;
	logic signed [15:0] mixed_sample;
	logic accepted;
	logic [15:0] refill_mask;
	logic [11:0] voice_fill;
	int errors, pending;
	int cycles;
	bit no_gaps;

	multi_voice_fifo_audio_mixer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .voice(voice), .sample_in(sample_in),
		.gain_value(gain_value), .play_on(play_on),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.strobe(strobe), .mixed_sample(mixed_sample), .accepted(accepted),
		.refill_mask(refill_mask), .voice_fill(voice_fill)
	);

	mvfam_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .voice(voice), .sample_in(sample_in),
		.gain_value(gain_value), .play_on(play_on),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.strobe(strobe), .mixed_sample(mixed_sample), .accepted(accepted),
		.refill_mask(refill_mask), .voice_fill(voice_fill),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort on a hang: a stuck busy or a lost strobe must not run forever.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Issue one request and hold it until the block takes it.
	// Start stays high on return so a back-to-back request needs no extra edge.
	task automatic send_request(logic [2:0] o, logic [3:0] v, logic [15:0] s,
			logic [15:0] g, logic p);
		int gap;
		if (!no_gaps && $urandom_range(99) < 30) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		voice <= v;
		sample_in <= s;
		gain_value <= g;
		play_on <= p;
		// busy read right after the edge is the value the block sampled there
		do @(posedge clk); while (busy);
	endtask

	// Drain all results, then write the threshold while the block is idle.
	task automatic write_threshold(logic [11:0] value);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return UNITY_GAIN;
			2: return 16'hffff;
			3: return 16'd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	// Weighted random request: pushes dominate so the FIFOs have data to mix.
	task automatic random_request();
		int w;
		logic [2:0] o;
		w = $urandom_range(99);
		if (w < 40) o = OP_PUSH;
		else if (w < 60) o = OP_TICK;
		else if (w < 70) o = OP_PLAY;
		else if (w < 78) o = OP_GAIN;
		else if (w < 83) o = OP_CLEAR;
		else if (w < 94) o = OP_READ;
		else o = 3'($urandom_range(6, 7));
		send_request(o, 4'($urandom_range(15)), pick_sample(), pick_gain(),
			($urandom_range(9) < 7));
	endtask

	initial begin
		logic [11:0] thresholds [6];
		cycles = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_PUSH;
		voice = '0;
		sample_in = '0;
		gain_value = '0;
		play_on = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold.
		send_request(OP_PLAY, 4'd0, 16'h0, 16'h0, 1'b1);   // play on empty: flag
		send_request(OP_PLAY, 4'd0, 16'h0, 16'h0, 1'b1);   // again while playing
		send_request(OP_READ, 4'd0, 16'h0, 16'h0, 1'b0);
		send_request(OP_TICK, 4'd0, 16'h0, 16'h0, 1'b0);   // empty playing voice
		send_request(OP_PUSH, 4'd0, 16'h7fff, 16'h0, 1'b0);
		send_request(OP_PUSH, 4'd0, 16'h8000, 16'h0, 1'b0);
		send_request(OP_PUSH, 4'd15, 16'h7fff, 16'h0, 1'b0);
		send_request(OP_PUSH, 4'd15, 16'h8000, 16'h0, 1'b0);
		send_request(OP_PUSH, 4'd7, 16'hffff, 16'h0, 1'b0);
		send_request(OP_GAIN, 4'd0, 16'h0, 16'hffff, 1'b0);  // above unity
		send_request(OP_PLAY, 4'd15, 16'h0, 16'h0, 1'b1);
		send_request(OP_PLAY, 4'd7, 16'h0, 16'h0, 1'b1);
		send_request(OP_TICK, 4'd3, 16'h0, 16'h0, 1'b0);     // clamp high
		send_request(OP_GAIN, 4'd15, 16'h0, 16'h0, 1'b0);    // zero gain
		send_request(OP_TICK, 4'd15, 16'h0, 16'h0, 1'b0);
		send_request(OP_READ, 4'd0, 16'h0, 16'h0, 1'b0);
		send_request(3'd6, 4'd7, 16'hffff, 16'hffff, 1'b1);
		send_request(3'd7, 4'd7, 16'hffff, 16'hffff, 1'b1);
		send_request(OP_CLEAR, 4'd7, 16'h0, 16'h0, 1'b0);
		send_request(OP_PLAY, 4'd0, 16'h0, 16'h0, 1'b0);
		send_request(OP_TICK, 4'd0, 16'h0, 16'h0, 1'b0);
		send_request(OP_READ, 4'd0, 16'h0, 16'h0, 1'b0);

		// Load one voice with a burst of pushes at full rate.
		write_threshold(12'd4095);
		no_gaps = 1'b1;
		for (int i = 0; i < 20; i++)
			send_request(OP_PUSH, 4'd3, 16'($urandom), 16'h0, 1'b0);
		no_gaps = 1'b0;
		send_request(OP_GAIN, 4'd3, 16'h0, 16'hffff, 1'b0);
		send_request(OP_PLAY, 4'd3, 16'h0, 16'h0, 1'b1);
		send_request(OP_TICK, 4'd0, 16'h0, 16'h0, 1'b0);
		send_request(OP_PUSH, 4'd3, 16'h8000, 16'h0, 1'b0);
		send_request(OP_READ, 4'd0, 16'h0, 16'h0, 1'b0);
		send_request(OP_CLEAR, 4'd3, 16'h0, 16'h0, 1'b0);

		// Random part over several thresholds; small ones sit near real fill levels.
		thresholds = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(2, 6)),
			12'($urandom), 12'd2048};
		foreach (thresholds[t]) begin
			write_threshold(thresholds[t]);
			for (int i = 0; i < 68; i++) begin
				no_gaps = (t == 2) && (i >= 10) && (i < 60);
				random_request();
			end
		end
		no_gaps = 1'b0;

		// Drain and let the block settle past its longest tick.
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/core/mvfam_pkg.sv
rtl/core/mvfam_ctrl.sv
rtl/core/mvfam_dp.sv
rtl/core/multi_voice_fifo_audio_mixer.sv
dv/mvfam_checker.sv
dv/tb.sv
